// ----- rtl/core/indexed_list_insert_remove_core_assert.svh -----
// Assertion macros used by the list core checker.
`ifndef INDEXED_LIST_INSERT_REMOVE_CORE_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_CORE_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define ILIR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define ILIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ilir_pkg.sv -----
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared constants, codes and control structs of the indexed list core.
// ----------------------------------------------------------------------------
package ilir_pkg;

  // Store geometry
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_READ   = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Read address source
  typedef enum logic [1:0] {
    RS_IDX   = 2'd0,
    RS_BELOW = 2'd1,
    RS_ABOVE = 2'd2
  } rd_sel_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic    latch_req;
    logic    latch_status;
    logic    ld_ptr;
    logic    ptr_inc;
    logic    ptr_dec;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_value;
    logic    wr_move;
    logic    cap_vout;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    finish;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic err;
    logic is_seq;
    logic is_remove;
    logic at_target;
    logic at_last;
  } sts_t;

endpackage

// ----- rtl/core/ilir_dpath.sv -----
// ----------------------------------------------------------------------------
// ilir_dpath
// Request registers, entry memory, count, shift pointer and result registers.
// ----------------------------------------------------------------------------
module ilir_dpath import ilir_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [1:0]          operation_i,
  input  logic [INDEX_W-1:0]  index_i,
  input  logic [HANDLE_W-1:0] value_i,
  output logic                done_o,
  output logic [HANDLE_W-1:0] value_out_o,
  output logic [CNT_W-1:0]    count_o,
  output logic                is_empty_o,
  output logic [1:0]          status_o
);

  op_e                 op_q;
  logic [INDEX_W-1:0]  idx_q;
  logic [HANDLE_W-1:0] val_q;
  status_e             st_q;
  status_e             st_calc;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    ptr_q;
  logic [CNT_W-1:0]    ptr_dn, ptr_up, ins_pos;
  logic [CMP_W-1:0]    cnt_ext, idx_ext;
  logic                is_full;
  logic [HANDLE_W-1:0] mem [CAPACITY];
  logic [HANDLE_W-1:0] rd_data_q;
  logic [HANDLE_W-1:0] vout_q;
  logic [ADDR_W-1:0]   rd_addr, wr_addr;
  logic [HANDLE_W-1:0] wr_data;
  logic                mem_we;
  logic                done_q;
  logic [HANDLE_W-1:0] res_val_q;
  logic [CNT_W-1:0]    res_cnt_q;
  logic                res_empty_q;
  status_e             res_st_q;

  // Hold the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      op_q  <= op_e'(operation_i);
      idx_q <= index_i;
      val_q <= value_i;
    end
  end

  // Check range and fill level against the current count
  assign cnt_ext = CMP_W'(count_q);
  assign idx_ext = CMP_W'(idx_q);
  assign is_full = (count_q == CNT_W'(CAPACITY));

  always_comb begin
    unique case (op_q)
      OP_APPEND: st_calc = is_full ? ST_FULL : ST_OK;
      OP_INSERT: begin
        if (idx_ext > cnt_ext) st_calc = ST_RANGE;
        else if (is_full)      st_calc = ST_FULL;
        else                   st_calc = ST_OK;
      end
      default:   st_calc = (idx_ext >= cnt_ext) ? ST_RANGE : ST_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_status) st_q <= st_calc;
  end

  // Walk the shift pointer
  assign ptr_dn  = ptr_q - CNT_W'(1);
  assign ptr_up  = ptr_q + CNT_W'(1);
  assign ins_pos = (op_q == OP_APPEND) ? count_q : CNT_W'(idx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_ptr)       ptr_q <= (op_q == OP_REMOVE) ? CNT_W'(idx_q) : count_q;
    else if (cmd_i.ptr_inc) ptr_q <= ptr_up;
    else if (cmd_i.ptr_dec) ptr_q <= ptr_dn;
  end

  assign sts_o.err       = (st_calc != ST_OK);
  assign sts_o.is_seq    = (op_q == OP_APPEND) || (op_q == OP_INSERT);
  assign sts_o.is_remove = (op_q == OP_REMOVE);
  assign sts_o.at_target = (ptr_q == ins_pos);
  assign sts_o.at_last   = (ptr_up == count_q);

  // Select memory addresses and write data
  always_comb begin
    unique case (cmd_i.rd_sel)
      RS_IDX:   rd_addr = ADDR_W'(idx_q);
      RS_BELOW: rd_addr = ptr_dn[ADDR_W-1:0];
      RS_ABOVE: rd_addr = ptr_up[ADDR_W-1:0];
      default:  rd_addr = ADDR_W'(idx_q);
    endcase
  end

  assign wr_addr = ptr_q[ADDR_W-1:0];
  assign wr_data = cmd_i.wr_value ? val_q : rd_data_q;
  assign mem_we  = cmd_i.wr_value | cmd_i.wr_move;

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we)      mem[wr_addr] <= wr_data;
    if (cmd_i.rd_en) rd_data_q <= mem[rd_addr];
  end

  // Keep the handle that was read or removed
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_vout) vout_q <= rd_data_q;
  end

  // Advance the live count
  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc)      count_d = count_q + CNT_W'(1);
    else if (cmd_i.cnt_dec) count_d = count_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Strobe the result for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  // Load result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_val_q   <= ((st_q == ST_OK) && ((op_q == OP_READ) || (op_q == OP_REMOVE)))
                     ? vout_q : '0;
      res_cnt_q   <= count_d;
      res_empty_q <= (count_d == '0);
      res_st_q    <= st_q;
    end
  end

  assign done_o      = done_q;
  assign value_out_o = res_val_q;
  assign count_o     = res_cnt_q;
  assign is_empty_o  = res_empty_q;
  assign status_o    = res_st_q;

endmodule

// ----- rtl/core/ilir_ctrl.sv -----
// ----------------------------------------------------------------------------
// ilir_ctrl
// Sequencer for append, insert, read and remove over the entry memory.
// ----------------------------------------------------------------------------
module ilir_ctrl import ilir_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_EXEC   = 8'b0000_0010,
    S_FETCH  = 8'b0000_0100,
    S_INS_RD = 8'b0000_1000,
    S_INS_MV = 8'b0001_0000,
    S_REM_RD = 8'b0010_0000,
    S_REM_MV = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Decode next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RS_IDX;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch_req = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.latch_status = 1'b1;
        cmd_o.ld_ptr       = 1'b1;
        if (sts_i.err) begin
          state_d = S_FINISH;
        end else if (sts_i.is_seq) begin
          state_d = S_INS_RD;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.cap_vout = 1'b1;
        state_d = sts_i.is_remove ? S_REM_RD : S_FINISH;
      end
      S_INS_RD: begin
        if (sts_i.at_target) begin
          cmd_o.wr_value = 1'b1;
          cmd_o.cnt_inc  = 1'b1;
          cmd_o.finish   = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RS_BELOW;
          state_d = S_INS_MV;
        end
      end
      S_INS_MV: begin
        cmd_o.wr_move = 1'b1;
        cmd_o.ptr_dec = 1'b1;
        state_d = S_INS_RD;
      end
      S_REM_RD: begin
        if (sts_i.at_last) begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.finish  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RS_ABOVE;
          state_d = S_REM_MV;
        end
      end
      S_REM_MV: begin
        cmd_o.wr_move = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        state_d = S_REM_RD;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- rtl/core/indexed_list_insert_remove_core.sv -----
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_core
// Ordered list of handles in a fixed store with append, insert, read, remove.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Payload
//  request   start (in), busy (out)  operation_i, index_i, value_i
//  result    done_o strobe (out)     value_out_o, count_o, is_empty_o, status_o
//
// A request is taken when start is high and busy is low. Shifts move one entry
// at a time over the single read and single write port of the entry memory.
// done_o pulses in the same cycle in which busy falls; a new request may start then.
// Reset clears the count and control only; the entry memory needs no clear.
module indexed_list_insert_remove_core import ilir_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          operation_i,
  input  logic [INDEX_W-1:0]  index_i,
  input  logic [HANDLE_W-1:0] value_i,
  output logic                done_o,
  output logic [HANDLE_W-1:0] value_out_o,
  output logic [CNT_W-1:0]    count_o,
  output logic                is_empty_o,
  output logic [1:0]          status_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequence the request
  ilir_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Store, count and results
  ilir_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .operation_i(operation_i),
    .index_i    (index_i),
    .value_i    (value_i),
    .done_o     (done_o),
    .value_out_o(value_out_o),
    .count_o    (count_o),
    .is_empty_o (is_empty_o),
    .status_o   (status_o)
  );

endmodule

// ----- rtl/core/ilir_checker.sv -----
// ----------------------------------------------------------------------------
// ilir_checker
// Port-level checks of the indexed list core, bound to the top level.
// ----------------------------------------------------------------------------
`include "indexed_list_insert_remove_core_assert.svh"

module ilir_checker import ilir_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input logic [HANDLE_W-1:0] value_out_o,
  input logic [CNT_W-1:0]    count_o,
  input logic                is_empty_o,
  input logic [1:0]          status_o
);

  // A taken request keeps the core busy
  `ILIR_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy not raised")

  // One strobe per request
  `ILIR_ASSERT_NEXT(a_single_strobe, done_o, !done_o, "result strobe repeated")

  // Empty flag tracks the count
  `ILIR_ASSERT_SAME(a_empty_flag, done_o, is_empty_o == (count_o == '0), "empty flag wrong")

  // Failed requests return no handle
  `ILIR_ASSERT_SAME(a_err_no_value, done_o && (status_o != ST_OK), value_out_o == '0,
    "handle on error")

  // Count never exceeds the store
  `ILIR_ASSERT_SAME(a_count_cap, done_o, count_o <= CNT_W'(CAPACITY), "count over capacity")

endmodule

bind indexed_list_insert_remove_core ilir_checker u_ilir_checker (.*);
